[rtl/pid_position_and_incremental_macros.svh]
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared property forms for the checks at the end of the controller module.
// ----------------------------------------------------------------------------
`ifndef PID_POSITION_AND_INCREMENTAL_MACROS_SVH
`define PID_POSITION_AND_INCREMENTAL_MACROS_SVH

// Same-cycle implication, clocked on clk and quiet during reset.
`define PIDPI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and quiet during reset.
`define PIDPI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pidpi_pkg.sv]
// ----------------------------------------------------------------------------
// PID controller package
// Types, codes and saturation helpers shared by the controller and its unit.
// ----------------------------------------------------------------------------
package pidpi_pkg;

  localparam int DW = 32;
  localparam int FB = 16;

  localparam logic signed [26:0] GAIN_LIM = 27'sd65536000;
  localparam logic [19:0]        DT_MAX   = 20'd655360;

  localparam logic [1:0] CMD_POS = 2'd0;
  localparam logic [1:0] CMD_INC = 2'd1;
  localparam logic [1:0] CMD_CLR = 2'd2;
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam logic [2:0] REG_GAIN_P  = 3'd0;
  localparam logic [2:0] REG_GAIN_I  = 3'd1;
  localparam logic [2:0] REG_GAIN_D  = 3'd2;
  localparam logic [2:0] REG_UPPER   = 3'd3;
  localparam logic [2:0] REG_LOWER   = 3'd4;
  localparam logic [2:0] REG_ILIMIT  = 3'd5;
  localparam logic [2:0] REG_DBAND   = 3'd6;
  localparam logic [2:0] REG_SMOOTH  = 3'd7;

  typedef enum logic {OP_MUL, OP_DIV} op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FILT_A, ST_FILT_B,
    ST_POS_P, ST_POS_INT, ST_POS_IT, ST_POS_DM, ST_POS_DD, ST_POS_LIM, ST_POS_BC,
    ST_INC_DP, ST_INC_DI1, ST_INC_DI2, ST_INC_DDM, ST_INC_DDD, ST_INC_LIM,
    ST_FIN
  } state_t;

  function automatic logic signed [31:0] sat_w(input logic signed [35:0] x);
    logic signed [31:0] r;
    if (x > 36'sd2147483647) r = 32'sh7FFFFFFF;
    else if (x < -36'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [26:0] clamp_gain(input logic [26:0] g);
    logic signed [26:0] r;
    r = $signed(g);
    if (r > GAIN_LIM) r = GAIN_LIM;
    else if (r < -GAIN_LIM) r = -GAIN_LIM;
    return r;
  endfunction

  function automatic logic uses_unit(input state_t s);
    logic r;
    case (s)
      ST_IDLE, ST_POS_LIM, ST_INC_LIM, ST_FIN: r = 1'b0;
      default: r = 1'b1;
    endcase
    return r;
  endfunction

endpackage

[rtl/pidpi_muldiv.sv]
// ----------------------------------------------------------------------------
// PID shared multiply and divide unit
// Bit-serial sign-magnitude unit: a*b rounded at 16 fractional bits, or
// (a<<16)/b truncated, both saturated to the signed 32-bit range.
// ----------------------------------------------------------------------------
module pidpi_muldiv (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pidpi_pkg::op_t     op,
  input  logic signed [35:0] opa,
  input  logic signed [31:0] opb,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] res
);

  logic           busy_r;
  logic           done_r;
  pidpi_pkg::op_t op_r;
  logic           neg_r;
  logic [5:0]     cnt_r;
  logic [67:0]    mcand_r;
  logic [67:0]    prod_r;
  logic [47:0]    num_r;
  logic [31:0]    rem_r;
  logic [31:0]    den_r;

  logic [35:0] mag_a;
  logic [31:0] mag_b;
  logic [32:0] trial;
  logic [67:0] rnd;
  logic [51:0] m;
  logic [31:0] mlow;

  assign mag_a = opa[35] ? 36'(-opa) : 36'(opa);
  assign mag_b = opb[31] ? 32'(-opb) : 32'(opb);
  assign trial = {rem_r, num_r[47]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= (op == pidpi_pkg::OP_MUL) ? 6'd31 : 6'd47;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r    <= op;
      neg_r   <= opa[35] ^ opb[31];
      mcand_r <= 68'(mag_a);
      prod_r  <= '0;
      num_r   <= (op == pidpi_pkg::OP_MUL) ? 48'(mag_b) : {mag_a[31:0], 16'b0};
      rem_r   <= '0;
      den_r   <= mag_b;
    end else if (busy_r) begin
      if (op_r == pidpi_pkg::OP_MUL) begin
        if (num_r[0]) prod_r <= prod_r + mcand_r;
        mcand_r <= {mcand_r[66:0], 1'b0};
        num_r   <= {1'b0, num_r[47:1]};
      end else if (!trial[32]) begin
        rem_r <= trial[31:0];
        num_r <= {num_r[46:0], 1'b1};
      end else begin
        rem_r <= {rem_r[30:0], num_r[47]};
        num_r <= {num_r[46:0], 1'b0};
      end
    end
  end

  assign rnd  = prod_r + 68'd32768;
  assign m    = (op_r == pidpi_pkg::OP_MUL) ? rnd[67:16] : {4'b0, num_r};
  assign mlow = m[31:0];

  always_comb begin
    if (op_r == pidpi_pkg::OP_DIV && den_r == 32'd0) res = '0;
    else if (m > 52'h7FFFFFFF) res = neg_r ? 32'sh80000000 : 32'sh7FFFFFFF;
    else res = neg_r ? $signed(~mlow + 32'd1) : $signed(mlow);
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

[rtl/pid_position_and_incremental.sv]
// ----------------------------------------------------------------------------
// PID controller, positional and incremental
// Q16.16 PID step with dead band, error filter, integral clamp and
// back-calculation anti-windup, on one bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
// Clear, unused-command and zero-period items give their result in the cycle
// after acceptance. Other items pass through the shared unit, one operation
// at a time: a positional step runs six multiplies and one or two divides,
// an incremental step six multiplies and one divide. in_tready is low while
// an item is in work.
module pid_position_and_incremental (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // target[31:0], measured[63:32], period[83:64]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // drive[31:0]
  output logic [1:0]  out_tuser,  // saturated[0], held[1]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  `include "pid_position_and_incremental_macros.svh"

  logic [26:0] gp_r, gi_r, gd_r;
  logic [31:0] up_r, lo_r;
  logic [30:0] ilim_r, db_r;
  logic [15:0] alpha_r;

  logic signed [31:0] isum_r, le_r, ebl_r, ld_r, se_r;
  logic signed [31:0] err_r, f_r, p_r, it_r, t_r, d_r, drv_r;
  logic [19:0]        dt_r;
  logic [1:0]         cmd_r;
  logic               large_r, sat_r;

  logic               out_valid_r, out_sat_r, out_held_r;
  logic signed [31:0] out_drive_r;

  pidpi_pkg::state_t state_r, state_nxt;
  logic              issue_r, issue_nxt;

  logic               u_start, u_busy, u_done;
  pidpi_pkg::op_t     u_op;
  logic signed [35:0] u_a;
  logic signed [31:0] u_b, u_res;

  logic               cfg_wr, acc;
  logic signed [31:0] tgt, meas, e_sat, err_db;
  logic [19:0]        period, dt_cl;
  logic signed [35:0] diff;
  logic signed [32:0] e33;
  logic [32:0]        abs_e, abs_db;
  logic signed [26:0] gp_c, gi_c, gd_c, ig;
  logic signed [26:0] ig_used;
  logic signed [27:0] gi_t;
  logic signed [31:0] hi, lo, u_pos, u_inc, u_sel, lim, bc_a, ilim_s, f_new, s_int;
  logic               lim_sat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r    <= '0;
      gi_r    <= '0;
      gd_r    <= '0;
      up_r    <= 32'd65536000;
      lo_r    <= 32'(-32'sd65536000);
      ilim_r  <= 31'd65536000;
      db_r    <= '0;
      alpha_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        pidpi_pkg::REG_GAIN_P: gp_r    <= cfg_pwdata[26:0];
        pidpi_pkg::REG_GAIN_I: gi_r    <= cfg_pwdata[26:0];
        pidpi_pkg::REG_GAIN_D: gd_r    <= cfg_pwdata[26:0];
        pidpi_pkg::REG_UPPER:  up_r    <= cfg_pwdata;
        pidpi_pkg::REG_LOWER:  lo_r    <= cfg_pwdata;
        pidpi_pkg::REG_ILIMIT: ilim_r  <= cfg_pwdata[30:0];
        pidpi_pkg::REG_DBAND:  db_r    <= cfg_pwdata[30:0];
        pidpi_pkg::REG_SMOOTH: alpha_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      pidpi_pkg::REG_GAIN_P: cfg_prdata = 32'(gp_r);
      pidpi_pkg::REG_GAIN_I: cfg_prdata = 32'(gi_r);
      pidpi_pkg::REG_GAIN_D: cfg_prdata = 32'(gd_r);
      pidpi_pkg::REG_UPPER:  cfg_prdata = up_r;
      pidpi_pkg::REG_LOWER:  cfg_prdata = lo_r;
      pidpi_pkg::REG_ILIMIT: cfg_prdata = 32'(ilim_r);
      pidpi_pkg::REG_DBAND:  cfg_prdata = 32'(db_r);
      pidpi_pkg::REG_SMOOTH: cfg_prdata = 32'(alpha_r);
      default:               cfg_prdata = '0;
    endcase
  end

  // Front end of an item: error, dead band, large-error flag, period clamp.
  assign tgt    = $signed(in_tdata[31:0]);
  assign meas   = $signed(in_tdata[63:32]);
  assign period = in_tdata[83:64];
  assign diff   = 36'(tgt) - 36'(meas);
  assign e_sat  = pidpi_pkg::sat_w(diff);
  assign e33    = 33'(e_sat);
  assign abs_e  = e33[32] ? 33'(-e33) : 33'(e33);
  assign err_db = (abs_e < {2'b0, db_r}) ? 32'sd0 : e_sat;
  assign abs_db = (abs_e < {2'b0, db_r}) ? 33'd0 : abs_e;
  assign dt_cl  = (period > pidpi_pkg::DT_MAX) ? pidpi_pkg::DT_MAX : period;

  assign gp_c = pidpi_pkg::clamp_gain(gp_r);
  assign gi_c = pidpi_pkg::clamp_gain(gi_r);
  assign gd_c = pidpi_pkg::clamp_gain(gd_r);
  assign gi_t = 28'(gi_c) + 28'($signed({27'b0, gi_c[26]}));
  assign ig   = gi_t[27:1];

  assign hi     = ($signed(up_r) > $signed(lo_r)) ? $signed(up_r) : $signed(lo_r);
  assign lo     = ($signed(up_r) > $signed(lo_r)) ? $signed(lo_r) : $signed(up_r);
  assign u_pos  = pidpi_pkg::sat_w(36'(p_r) + 36'(it_r) + 36'(d_r));
  assign u_inc  = pidpi_pkg::sat_w(36'(ld_r) + 36'(u_pos));
  assign u_sel  = (state_r == pidpi_pkg::ST_POS_LIM) ? u_pos : u_inc;
  assign lim    = (u_sel > hi) ? hi : ((u_sel < lo) ? lo : u_sel);
  assign lim_sat = (u_sel > hi) || (u_sel < lo);
  assign bc_a   = pidpi_pkg::sat_w(36'(drv_r) - 36'(p_r) - 36'(d_r));

  assign ilim_s = $signed({1'b0, ilim_r});
  assign f_new  = pidpi_pkg::sat_w(36'(t_r) + 36'(u_res));
  assign s_int  = pidpi_pkg::sat_w(36'(isum_r) + 36'(u_res));

  assign in_tready = (state_r == pidpi_pkg::ST_IDLE) && (!out_valid_r || out_tready);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pidpi_pkg::ST_IDLE: begin
        if (acc && in_tuser inside {pidpi_pkg::CMD_POS, pidpi_pkg::CMD_INC} &&
            period != 20'd0) begin
          state_nxt = pidpi_pkg::ST_FILT_A;
        end
      end
      pidpi_pkg::ST_FILT_A:  if (u_done) state_nxt = pidpi_pkg::ST_FILT_B;
      pidpi_pkg::ST_FILT_B: begin
        if (u_done) begin
          state_nxt = (cmd_r == pidpi_pkg::CMD_POS) ? pidpi_pkg::ST_POS_P
                                                   : pidpi_pkg::ST_INC_DP;
        end
      end
      pidpi_pkg::ST_POS_P:   if (u_done) state_nxt = pidpi_pkg::ST_POS_INT;
      pidpi_pkg::ST_POS_INT: if (u_done) state_nxt = pidpi_pkg::ST_POS_IT;
      pidpi_pkg::ST_POS_IT:  if (u_done) state_nxt = pidpi_pkg::ST_POS_DM;
      pidpi_pkg::ST_POS_DM:  if (u_done) state_nxt = pidpi_pkg::ST_POS_DD;
      pidpi_pkg::ST_POS_DD:  if (u_done) state_nxt = pidpi_pkg::ST_POS_LIM;
      pidpi_pkg::ST_POS_LIM: begin
        state_nxt = (lim_sat && gi_c != 27'sd0) ? pidpi_pkg::ST_POS_BC
                                                : pidpi_pkg::ST_FIN;
      end
      pidpi_pkg::ST_POS_BC:  if (u_done) state_nxt = pidpi_pkg::ST_FIN;
      pidpi_pkg::ST_INC_DP:  if (u_done) state_nxt = pidpi_pkg::ST_INC_DI1;
      pidpi_pkg::ST_INC_DI1: if (u_done) state_nxt = pidpi_pkg::ST_INC_DI2;
      pidpi_pkg::ST_INC_DI2: if (u_done) state_nxt = pidpi_pkg::ST_INC_DDM;
      pidpi_pkg::ST_INC_DDM: if (u_done) state_nxt = pidpi_pkg::ST_INC_DDD;
      pidpi_pkg::ST_INC_DDD: if (u_done) state_nxt = pidpi_pkg::ST_INC_LIM;
      pidpi_pkg::ST_INC_LIM: state_nxt = pidpi_pkg::ST_FIN;
      pidpi_pkg::ST_FIN:     if (!out_valid_r || out_tready) state_nxt = pidpi_pkg::ST_IDLE;
      default:               state_nxt = pidpi_pkg::ST_IDLE;
    endcase
  end

  assign issue_nxt = pidpi_pkg::uses_unit(state_nxt) && (state_nxt != state_r);
  assign u_start   = issue_r;

  always_comb begin
    u_op = pidpi_pkg::OP_MUL;
    u_a  = '0;
    u_b  = '0;
    case (state_r)
      pidpi_pkg::ST_FILT_A: begin
        u_a = 36'($signed({1'b0, alpha_r}));
        u_b = se_r;
      end
      pidpi_pkg::ST_FILT_B: begin
        u_a = 36'(18'h10000 - {2'b0, alpha_r});
        u_b = err_r;
      end
      pidpi_pkg::ST_POS_P: begin
        u_a = 36'(gp_c);
        u_b = f_r;
      end
      pidpi_pkg::ST_POS_INT: begin
        u_a = 36'(f_r);
        u_b = $signed({12'b0, dt_r});
      end
      pidpi_pkg::ST_POS_IT: begin
        u_a = 36'(ig_used);
        u_b = isum_r;
      end
      pidpi_pkg::ST_POS_DM, pidpi_pkg::ST_INC_DP: begin
        u_a = 36'(f_r) - 36'(le_r);
        u_b = (state_r == pidpi_pkg::ST_POS_DM) ? 32'(gd_c) : 32'(gp_c);
      end
      pidpi_pkg::ST_POS_DD, pidpi_pkg::ST_INC_DDD: begin
        u_op = pidpi_pkg::OP_DIV;
        u_a  = 36'(t_r);
        u_b  = $signed({12'b0, dt_r});
      end
      pidpi_pkg::ST_POS_BC: begin
        u_op = pidpi_pkg::OP_DIV;
        u_a  = 36'(bc_a);
        u_b  = 32'(gi_c);
      end
      pidpi_pkg::ST_INC_DI1: begin
        u_a = 36'(gi_c);
        u_b = f_r;
      end
      pidpi_pkg::ST_INC_DI2: begin
        u_a = 36'(t_r);
        u_b = $signed({12'b0, dt_r});
      end
      pidpi_pkg::ST_INC_DDM: begin
        u_a = 36'(f_r) - (36'(le_r) <<< 1) + 36'(ebl_r);
        u_b = 32'(gd_c);
      end
      default: ;
    endcase
  end

  pidpi_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (u_start),
    .op    (u_op),
    .opa   (u_a),
    .opb   (u_b),
    .busy  (u_busy),
    .done  (u_done),
    .res   (u_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pidpi_pkg::ST_IDLE;
      issue_r     <= 1'b0;
      out_valid_r <= 1'b0;
      isum_r      <= '0;
      le_r        <= '0;
      ebl_r       <= '0;
      ld_r        <= '0;
      se_r        <= '0;
    end else begin
      state_r <= state_nxt;
      issue_r <= issue_nxt;

      if (acc && (in_tuser inside {pidpi_pkg::CMD_CLR, pidpi_pkg::CMD_NOP} ||
                  period == 20'd0)) begin
        out_valid_r <= 1'b1;
      end else if (state_r == pidpi_pkg::ST_FIN && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (acc && in_tuser == pidpi_pkg::CMD_CLR) begin
        isum_r <= '0;
        le_r   <= '0;
        ebl_r  <= '0;
        ld_r   <= '0;
        se_r   <= '0;
      end

      if (u_done) begin
        case (state_r)
          pidpi_pkg::ST_FILT_B: se_r <= f_new;
          pidpi_pkg::ST_POS_INT: begin
            if (s_int > ilim_s) isum_r <= ilim_s;
            else if (s_int < -ilim_s) isum_r <= -ilim_s;
            else isum_r <= s_int;
          end
          pidpi_pkg::ST_POS_BC: isum_r <= u_res;
          default: ;
        endcase
      end

      if (state_r == pidpi_pkg::ST_POS_LIM) begin
        le_r <= f_r;
        ld_r <= lim;
      end
      if (state_r == pidpi_pkg::ST_INC_LIM) begin
        ebl_r <= le_r;
        le_r  <= f_r;
        ld_r  <= lim;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r   <= in_tuser;
      err_r   <= err_db;
      dt_r    <= dt_cl;
      large_r <= {abs_db[31:0], 1'b0} > {3'b0, ilim_r} || abs_db[32];
      out_sat_r <= 1'b0;
      out_held_r <= (in_tuser != pidpi_pkg::CMD_CLR) && (in_tuser != pidpi_pkg::CMD_NOP) &&
                    (period == 20'd0);
      out_drive_r <= (in_tuser == pidpi_pkg::CMD_CLR) ? 32'sd0 : ld_r;
    end
    if (u_done) begin
      case (state_r)
        pidpi_pkg::ST_FILT_A:  t_r  <= u_res;
        pidpi_pkg::ST_FILT_B:  f_r  <= f_new;
        pidpi_pkg::ST_POS_P:   p_r  <= u_res;
        pidpi_pkg::ST_INC_DP:  p_r  <= u_res;
        pidpi_pkg::ST_POS_IT:  it_r <= u_res;
        pidpi_pkg::ST_INC_DI2: it_r <= u_res;
        pidpi_pkg::ST_POS_DM:  t_r  <= u_res;
        pidpi_pkg::ST_INC_DI1: t_r  <= u_res;
        pidpi_pkg::ST_INC_DDM: t_r  <= u_res;
        pidpi_pkg::ST_POS_DD:  d_r  <= u_res;
        pidpi_pkg::ST_INC_DDD: d_r  <= u_res;
        default: ;
      endcase
    end
    if (state_r == pidpi_pkg::ST_POS_LIM || state_r == pidpi_pkg::ST_INC_LIM) begin
      drv_r <= lim;
      sat_r <= lim_sat;
    end
    if (state_r == pidpi_pkg::ST_FIN && (!out_valid_r || out_tready)) begin
      out_drive_r <= drv_r;
      out_sat_r   <= sat_r;
      out_held_r  <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = {out_held_r, out_sat_r};

  // The ig term uses the halved gain only when the error is large.
  assign ig_used = large_r ? ig : gi_c;

  `PIDPI_ASSERT_IMP(a_start_free, u_start, !u_busy, "shared unit started while busy")
  `PIDPI_ASSERT_IMP(a_done_owned, u_done, pidpi_pkg::uses_unit(state_r), "unit result with no owner")
  `PIDPI_ASSERT_NXT(a_accept_moves, acc, (state_r != pidpi_pkg::ST_IDLE) || out_valid_r, "item lost")

endmodule
